### hdl/lpht_pkg.sv
// Shared constants, codes and types for the linear probing hash table unit.
package lpht_pkg;

	localparam int KEY_W          = 31;
	localparam int OP_W           = 2;
	localparam int STAT_W         = 3;
	localparam int TABLE_SIZE_DEF = 16;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 8;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_DELETED  = 3'd4;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} slot_cmd_t;

endpackage

### hdl/lpht_home.sv
// Home slot unit: the key modulo the table size by reciprocal multiplication.
module lpht_home
	import lpht_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_W-1:0]              key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] home
);

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int SHIFT   = KEY_W + IDX_W;
	localparam int RECIP_W = KEY_W + 1;
	localparam int PROD_W  = KEY_W + RECIP_W;
	// The rounded-up reciprocal gives the exact quotient for every key of KEY_W bits.
	localparam logic [63:0] RECIP_L =
		((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_L);
	localparam logic [IDX_W-1:0]   DIV_LO = IDX_W'(TABLE_SIZE);

	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  quot_lo_s1;
	logic [IDX_W-1:0]  key_lo_s1;
	logic              vld_s1;
	logic [IDX_W-1:0]  back_lo;
	logic [IDX_W-1:0]  home_q;
	logic              done_q;

	assign prod = PROD_W'(key) * PROD_W'(RECIP);

	// The remainder is below the table size, so its low index bits are all that is needed.
	assign back_lo = quot_lo_s1 * DIV_LO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_lo_s1 <= prod[SHIFT +: IDX_W];
			key_lo_s1  <= key[IDX_W-1:0];
		end
		if (vld_s1) begin
			home_q <= key_lo_s1 - back_lo;
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

### hdl/lpht_slot_ram.sv
// Key slot memory with separate read and write addresses and a registered read.
module lpht_slot_ram
	import lpht_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  slot_cmd_t                     cmd,
	input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
	input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
	input  logic [KEY_W-1:0]              wr_data,
	output logic [KEY_W-1:0]              rd_data
);

	logic [KEY_W-1:0] mem [TABLE_SIZE];
	logic [KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/linear_probe_hash_table_unit.sv
// Top level: probe sequencer of the linear probing hash table unit.
// From an accepted word to its result word the unit passes through the home slot unit's
// reciprocal multiplication, then k slot memory reads, where k (1 to TABLE_SIZE) is the
// number of slots probed, then the result register. One item is worked on at a time, so
// the next word is taken only after the result word is loaded, later while a result word
// waits on m_tready. After reset a clearing pass empties every slot, with s_tready low.
module linear_probe_hash_table_unit
	import lpht_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] opcode, [32:2] key, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // [2:0] status, rest zero
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] m_status_q;
	logic              m_tvalid_q;

	logic [OP_W-1:0]   in_op;
	logic [KEY_W-1:0]  in_key;
	logic              accept;
	logic              op_valid;
	logic              home_done;
	logic [IDX_W-1:0]  home;

	slot_cmd_t         cmd;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [KEY_W-1:0]  wr_data;
	logic [KEY_W-1:0]  rd_data;

	logic [IDX_W-1:0]  idx_nxt;
	logic              slot_empty;
	logic              slot_match;
	logic              last_slot;
	logic              finish;
	logic              advance;
	logic [STAT_W-1:0] fin_status;
	logic              out_load;

	assign in_op    = s_tdata[OP_W-1:0];
	assign in_key   = s_tdata[OP_W+KEY_W-1:OP_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign op_valid = (in_op inside {OP_INSERT, OP_SEARCH, OP_DELETE});

	lpht_home #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && op_valid),
		.key   (in_key),
		.done  (home_done),
		.home  (home)
	);

	lpht_slot_ram #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_ram (
		.clk    (clk),
		.cmd    (cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	assign idx_nxt    = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
	assign slot_empty = (rd_data == '0);
	assign slot_match = (rd_data == key_q);
	assign last_slot  = (cnt_q == CNT_W'(TABLE_SIZE - 1));

	// The probe decision for the slot whose read data has just arrived.
	always_comb begin
		finish     = 1'b0;
		advance    = 1'b0;
		fin_status = STAT_NOTFOUND;
		if (op_q == OP_INSERT) begin
			if (slot_empty) begin
				finish     = 1'b1;
				fin_status = STAT_INSERTED;
			end else if (last_slot) begin
				finish     = 1'b1;
				fin_status = STAT_FULL;
			end else begin
				advance = 1'b1;
			end
		end else begin
			if (slot_empty) begin
				finish = 1'b1;
			end else if (slot_match) begin
				finish     = 1'b1;
				fin_status = (op_q == OP_DELETE) ? STAT_DELETED : STAT_FOUND;
			end else if (last_slot) begin
				finish = 1'b1;
			end else begin
				advance = 1'b1;
			end
		end
	end

	always_comb begin
		cmd       = '0;
		rd_addr   = idx_nxt;
		wr_addr   = idx_q;
		wr_data   = key_q;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_en = 1'b1;
				wr_addr   = clr_q;
				wr_data   = '0;
			end
			S_HASH: begin
				cmd.rd_en = home_done;
				rd_addr   = home;
			end
			S_PROBE: begin
				cmd.rd_en = advance;
				if (finish && fin_status == STAT_INSERTED) begin
					cmd.wr_en = 1'b1;
				end else if (finish && fin_status == STAT_DELETED) begin
					cmd.wr_en = 1'b1;
					wr_data   = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && op_valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (home_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (finish) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
		if (state_q == S_HASH && home_done) begin
			idx_q <= home;
			cnt_q <= '0;
		end else if (state_q == S_PROBE && advance) begin
			idx_q <= idx_nxt;
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_PROBE && finish) begin
			status_q <= fin_status;
		end
		if (out_load) begin
			m_status_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - STAT_W){1'b0}}, m_status_q};

endmodule
